@@ rtl/kpvf_pkg.sv @@
`timescale 1ns / 1ps
// kpvf_pkg: shared constants, register codes, micro-op format and the
// micro-program of the position/velocity filter. Used by every rtl file.
package kpvf_pkg;

  // word and field sizes
  localparam int DataWidthDef = 32;
  localparam int IoWidth      = 32;
  localparam int TsWidth      = 24;
  localparam int NoiseWidth   = 31;
  localparam int FracP        = 24;
  localparam int AddrWidth    = 4;
  localparam int PcW          = 6;
  localparam int RegAddrW     = 5;
  localparam int NumRegs      = 18;

  // configuration register reset values
  localparam logic [TsWidth-1:0]    TsReset = 24'd167772;
  localparam logic [NoiseWidth-1:0] PnReset = 31'd838861;
  localparam logic [NoiseWidth-1:0] RnReset = 31'd16777;

  // configuration register indexes
  localparam logic [1:0] RegTimeStep     = 2'd0;
  localparam logic [1:0] RegProcessNoise = 2'd1;
  localparam logic [1:0] RegMeasureNoise = 2'd2;

  // request modes
  localparam logic [1:0] ModePredict = 2'd0;
  localparam logic [1:0] ModeUpdate  = 2'd1;
  localparam logic [1:0] ModeReset   = 2'd2;

  // micro-op codes
  typedef enum logic [3:0] {
    OP_END, OP_MUL, OP_ADD, OP_SUB, OP_SADD, OP_DIV, OP_CHK,
    OP_ZERO, OP_ONE, OP_LDA, OP_LDZ
  } op_e;

  // product scaling codes: shift right by FracP plus the code
  localparam logic [1:0] Sh24 = 2'd0;
  localparam logic [1:0] Sh25 = 2'd1;
  localparam logic [1:0] Sh26 = 2'd2;

  // register file addresses
  localparam logic [RegAddrW-1:0] A_POS  = 5'd0;
  localparam logic [RegAddrW-1:0] A_VEL  = 5'd1;
  localparam logic [RegAddrW-1:0] A_P00  = 5'd2;
  localparam logic [RegAddrW-1:0] A_P01  = 5'd3;
  localparam logic [RegAddrW-1:0] A_P10  = 5'd4;
  localparam logic [RegAddrW-1:0] A_P11  = 5'd5;
  localparam logic [RegAddrW-1:0] T_D2   = 5'd6;
  localparam logic [RegAddrW-1:0] T_D3   = 5'd7;
  localparam logic [RegAddrW-1:0] T_D4   = 5'd8;
  localparam logic [RegAddrW-1:0] T_Q00  = 5'd9;
  localparam logic [RegAddrW-1:0] T_Q01  = 5'd10;
  localparam logic [RegAddrW-1:0] T_Q11  = 5'd11;
  localparam logic [RegAddrW-1:0] T_A    = 5'd12;
  localparam logic [RegAddrW-1:0] T_B    = 5'd13;
  localparam logic [RegAddrW-1:0] T_N01  = 5'd14;
  localparam logic [RegAddrW-1:0] T_N10  = 5'd15;
  localparam logic [RegAddrW-1:0] T_N00  = 5'd16;
  localparam logic [RegAddrW-1:0] T_IN   = 5'd17;
  // update step reuses the predict temporaries
  localparam logic [RegAddrW-1:0] T_S    = T_D2;
  localparam logic [RegAddrW-1:0] T_K0   = T_D3;
  localparam logic [RegAddrW-1:0] T_K1   = T_D4;
  localparam logic [RegAddrW-1:0] T_Y    = T_Q00;
  // configuration sources
  localparam logic [RegAddrW-1:0] A_DT   = 5'd24;
  localparam logic [RegAddrW-1:0] A_QN   = 5'd25;
  localparam logic [RegAddrW-1:0] A_RN   = 5'd26;

  // program entry points
  localparam logic [PcW-1:0] PcPredict = 6'd0;
  localparam logic [PcW-1:0] PcUpdate  = 6'd25;
  localparam logic [PcW-1:0] PcClear   = 6'd44;
  localparam logic [PcW-1:0] PcEnd     = 6'd51;

  typedef struct packed {
    op_e                 op;
    logic [RegAddrW-1:0] dst;
    logic [RegAddrW-1:0] a;
    logic [RegAddrW-1:0] b;
    logic [1:0]          shf;
  } uop_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic rd;
    logic start;
    logic out_load;
    logic fault;
    uop_t uop;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic done;
    logic nonpos;
  } stat_t;

  function automatic uop_t mk(input op_e op, input logic [RegAddrW-1:0] dst,
                              input logic [RegAddrW-1:0] a,
                              input logic [RegAddrW-1:0] b, input logic [1:0] shf);
    uop_t u;
    u.op  = op;
    u.dst = dst;
    u.a   = a;
    u.b   = b;
    u.shf = shf;
    return u;
  endfunction

  // micro-program: predict, update, clear; anything else ends the item
  function automatic uop_t prog(input logic [PcW-1:0] pc);
    uop_t u;
    case (pc)
      // predict
      6'd0:  u = mk(OP_LDA, T_IN,  A_POS, A_POS, Sh24);
      6'd1:  u = mk(OP_MUL, T_D2,  A_DT,  A_DT,  Sh24);
      6'd2:  u = mk(OP_MUL, T_D3,  T_D2,  A_DT,  Sh24);
      6'd3:  u = mk(OP_MUL, T_D4,  T_D3,  A_DT,  Sh24);
      6'd4:  u = mk(OP_MUL, T_Q00, A_QN,  T_D4,  Sh26);
      6'd5:  u = mk(OP_MUL, T_Q01, A_QN,  T_D3,  Sh25);
      6'd6:  u = mk(OP_MUL, T_Q11, A_QN,  T_D2,  Sh24);
      6'd7:  u = mk(OP_MUL, T_A,   A_DT,  A_P11, Sh24);
      6'd8:  u = mk(OP_ADD, T_N01, A_P01, T_A,   Sh24);
      6'd9:  u = mk(OP_ADD, T_N10, A_P10, T_A,   Sh24);
      6'd10: u = mk(OP_MUL, T_A,   A_DT,  A_P10, Sh24);
      6'd11: u = mk(OP_ADD, T_B,   A_P00, T_A,   Sh24);
      6'd12: u = mk(OP_MUL, T_A,   A_DT,  T_N01, Sh24);
      6'd13: u = mk(OP_ADD, T_N00, T_B,   T_A,   Sh24);
      6'd14: u = mk(OP_MUL, T_A,   A_DT,  A_VEL, Sh24);
      6'd15: u = mk(OP_ADD, T_B,   A_POS, T_A,   Sh24);
      6'd16: u = mk(OP_MUL, T_A,   T_IN,  T_D2,  Sh25);
      6'd17: u = mk(OP_ADD, A_POS, T_B,   T_A,   Sh24);
      6'd18: u = mk(OP_MUL, T_A,   A_DT,  T_IN,  Sh24);
      6'd19: u = mk(OP_ADD, A_VEL, A_VEL, T_A,   Sh24);
      6'd20: u = mk(OP_ADD, A_P00, T_N00, T_Q00, Sh24);
      6'd21: u = mk(OP_ADD, A_P01, T_N01, T_Q01, Sh24);
      6'd22: u = mk(OP_ADD, A_P10, T_N10, T_Q01, Sh24);
      6'd23: u = mk(OP_ADD, A_P11, A_P11, T_Q11, Sh24);
      6'd24: u = mk(OP_END, A_POS, A_POS, A_VEL, Sh24);
      // update
      6'd25: u = mk(OP_LDZ, T_IN,  A_POS, A_POS, Sh24);
      6'd26: u = mk(OP_SADD, T_S,  A_P11, A_RN,  Sh24);
      6'd27: u = mk(OP_CHK, T_S,   T_S,   T_S,   Sh24);
      6'd28: u = mk(OP_DIV, T_K0,  A_P01, T_S,   Sh24);
      6'd29: u = mk(OP_DIV, T_K1,  A_P11, T_S,   Sh24);
      6'd30: u = mk(OP_SUB, T_Y,   T_IN,  A_VEL, Sh24);
      6'd31: u = mk(OP_MUL, T_A,   T_K0,  T_Y,   Sh24);
      6'd32: u = mk(OP_ADD, A_POS, A_POS, T_A,   Sh24);
      6'd33: u = mk(OP_MUL, T_A,   T_K1,  T_Y,   Sh24);
      6'd34: u = mk(OP_ADD, A_VEL, A_VEL, T_A,   Sh24);
      6'd35: u = mk(OP_MUL, T_A,   T_K0,  A_P10, Sh24);
      6'd36: u = mk(OP_SUB, A_P00, A_P00, T_A,   Sh24);
      6'd37: u = mk(OP_MUL, T_A,   T_K0,  A_P11, Sh24);
      6'd38: u = mk(OP_SUB, A_P01, A_P01, T_A,   Sh24);
      6'd39: u = mk(OP_MUL, T_A,   T_K1,  A_P10, Sh24);
      6'd40: u = mk(OP_SUB, A_P10, A_P10, T_A,   Sh24);
      6'd41: u = mk(OP_MUL, T_A,   T_K1,  A_P11, Sh24);
      6'd42: u = mk(OP_SUB, A_P11, A_P11, T_A,   Sh24);
      6'd43: u = mk(OP_END, A_POS, A_POS, A_VEL, Sh24);
      // clear
      6'd44: u = mk(OP_ZERO, A_POS, A_POS, A_POS, Sh24);
      6'd45: u = mk(OP_ZERO, A_VEL, A_POS, A_POS, Sh24);
      6'd46: u = mk(OP_ONE,  A_P00, A_POS, A_POS, Sh24);
      6'd47: u = mk(OP_ZERO, A_P01, A_POS, A_POS, Sh24);
      6'd48: u = mk(OP_ZERO, A_P10, A_POS, A_POS, Sh24);
      6'd49: u = mk(OP_ONE,  A_P11, A_POS, A_POS, Sh24);
      default: u = mk(OP_END, A_POS, A_POS, A_VEL, Sh24);
    endcase
    return u;
  endfunction

endpackage

@@ rtl/kpvf_if.sv @@
`timescale 1ns / 1ps
// kpvf_in_if / kpvf_out_if: valid/ready request channels of the filter.
// Widths come from kpvf_pkg.
interface kpvf_in_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        mode;
  logic signed [kpvf_pkg::IoWidth-1:0] accel;
  logic signed [kpvf_pkg::IoWidth-1:0] measured_velocity;

  modport source (output valid, mode, accel, measured_velocity, input ready);
  modport sink   (input valid, mode, accel, measured_velocity, output ready);
endinterface

interface kpvf_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [kpvf_pkg::IoWidth-1:0] position_estimate;
  logic signed [kpvf_pkg::IoWidth-1:0] velocity_estimate;
  logic                              divide_fault;

  modport source (output valid, position_estimate, velocity_estimate, divide_fault,
                  input ready);
  modport sink   (input valid, position_estimate, velocity_estimate, divide_fault,
                  output ready);
endinterface

@@ rtl/kalman_position_velocity_filter_core.sv @@
`timescale 1ns / 1ps
// kalman_position_velocity_filter_core: top level with configuration
// registers, sequencer and datapath. Depends on kpvf_pkg, kpvf_if, kpvf_ctrl,
// kpvf_datapath.
//
//   port    dir  kind     moves
//   in_i    in   request  mode, accel, measured_velocity
//   out_o   out  request  position_estimate, velocity_estimate, divide_fault
//   apb     in   config   time_step (0x0), q scale (0x4), r variance (0x8)
//
// Each micro-op passes through a read, a start and a wait state; a multiply or
// a divide holds the wait state until its unit finishes. The internal word is
// DATA_WIDTH, at least 32, plus 2.
// After reset the clear program runs before in_i.ready rises.
// A finished result waits in the output register; the next request is taken
// while it waits, and its result holds until that slot is free.
module kalman_position_velocity_filter_core #(
  parameter int DATA_WIDTH = kpvf_pkg::DataWidthDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  kpvf_in_if.sink                           in_i,
  kpvf_out_if.source                        out_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [kpvf_pkg::AddrWidth-1:0]    paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  logic [kpvf_pkg::TsWidth-1:0]    ts_q;
  logic [kpvf_pkg::NoiseWidth-1:0] pn_q, rn_q;
  logic [1:0]                      reg_idx;
  logic                            cfg_wr;

  kpvf_pkg::cmd_t  cmd;
  kpvf_pkg::stat_t stat;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ts_q <= kpvf_pkg::TsReset;
      pn_q <= kpvf_pkg::PnReset;
      rn_q <= kpvf_pkg::RnReset;
    end else if (cfg_wr) begin
      case (reg_idx)
        kpvf_pkg::RegTimeStep:     ts_q <= pwdata[kpvf_pkg::TsWidth-1:0];
        kpvf_pkg::RegProcessNoise: pn_q <= pwdata[kpvf_pkg::NoiseWidth-1:0];
        kpvf_pkg::RegMeasureNoise: rn_q <= pwdata[kpvf_pkg::NoiseWidth-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (reg_idx)
      kpvf_pkg::RegTimeStep:     prdata = 32'(ts_q);
      kpvf_pkg::RegProcessNoise: prdata = 32'(pn_q);
      kpvf_pkg::RegMeasureNoise: prdata = 32'(rn_q);
      default:                   prdata = '0;
    endcase
  end

  kpvf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_mode_i   (in_i.mode),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  kpvf_datapath #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .accel_i         (in_i.accel),
    .meas_i          (in_i.measured_velocity),
    .time_step_i     (ts_q),
    .q_scale_i       (pn_q),
    .r_var_i         (rn_q),
    .position_o      (out_o.position_estimate),
    .velocity_o      (out_o.velocity_estimate),
    .fault_o         (out_o.divide_fault)
  );

endmodule

@@ rtl/kpvf_datapath.sv @@
`timescale 1ns / 1ps
// kpvf_datapath: register file, sequential multiplier, restoring divider,
// saturating adder and result registers. Depends on kpvf_pkg.
module kpvf_datapath #(
  parameter int DATA_WIDTH = kpvf_pkg::DataWidthDef
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  kpvf_pkg::cmd_t                        cmd_i,
  output kpvf_pkg::stat_t                       stat_o,
  input  logic signed [kpvf_pkg::IoWidth-1:0]   accel_i,
  input  logic signed [kpvf_pkg::IoWidth-1:0]   meas_i,
  input  logic [kpvf_pkg::TsWidth-1:0]          time_step_i,
  input  logic [kpvf_pkg::NoiseWidth-1:0]       q_scale_i,
  input  logic [kpvf_pkg::NoiseWidth-1:0]       r_var_i,
  output logic signed [kpvf_pkg::IoWidth-1:0]   position_o,
  output logic signed [kpvf_pkg::IoWidth-1:0]   velocity_o,
  output logic                                  fault_o
);

  // internal word holds a saturated word, a noise setting or the wide S
  localparam int XW   = ((DATA_WIDTH > 32) ? DATA_WIDTH : 32) + 2;
  localparam int MW   = XW - 1;
  localparam int NCH  = (MW + 15) / 16;
  localparam int PW   = MW + 16 * NCH;
  localparam int NB   = MW + kpvf_pkg::FracP + 1;
  localparam int MCW  = $clog2(NCH + 1);
  localparam int DCW  = $clog2(NB + 1);
  localparam int IW   = kpvf_pkg::IoWidth;
  localparam longint WMaxL = (longint'(1) << (DATA_WIDTH - 1)) - 1;
  localparam logic signed [XW:0]   WMaxE   = (XW+1)'(WMaxL);
  localparam logic signed [XW:0]   WMinE   = (XW+1)'(-WMaxL - 1);
  localparam logic signed [XW-1:0] OneVal  = (DATA_WIDTH > 25) ?
                                             XW'(longint'(1) << kpvf_pkg::FracP) : XW'(WMaxL);
  localparam logic signed [XW-1:0] Out32Max = XW'(longint'(2147483647));
  localparam logic signed [XW-1:0] Out32Min = XW'(-longint'(2147483647) - 1);
  localparam logic [NB-1:0]        QIntMax  = NB'(WMaxL >>> kpvf_pkg::FracP);

  function automatic logic signed [XW-1:0] sat_w(input logic signed [XW:0] v);
    logic signed [XW-1:0] r;
    if (v > WMaxE) r = XW'(WMaxE);
    else if (v < WMinE) r = XW'(WMinE);
    else r = XW'(v);
    return r;
  endfunction

  function automatic logic signed [IW-1:0] sat_out(input logic signed [XW-1:0] v);
    logic signed [IW-1:0] r;
    if (v > Out32Max) r = IW'(Out32Max);
    else if (v < Out32Min) r = IW'(Out32Min);
    else r = IW'(v);
    return r;
  endfunction

  kpvf_pkg::uop_t uop;
  assign uop = cmd_i.uop;

  // register file and operand registers
  logic signed [XW-1:0] mem_q [kpvf_pkg::NumRegs];
  logic signed [XW-1:0] opa_q, opb_q;
  logic signed [IW-1:0] accel_q, meas_q;

  // write port
  logic                            wr_en;
  logic signed [XW-1:0]            wr_data;

  // multiplier state
  logic                 mul_busy_q;
  logic [MCW-1:0]       mcnt_q;
  logic [MW-1:0]        ua_q;
  logic [16*NCH-1:0]    mb_q;
  logic [PW-1:0]        acc_q;
  logic                 mneg_q;

  // divider state
  logic                 div_busy_q;
  logic [DCW-1:0]       dcnt_q;
  logic [NB-1:0]        dvd_q, quo_q;
  logic [XW:0]          rem_q;
  logic [XW-1:0]        den_q;
  logic                 dneg_q;

  logic done_q, nonpos_q;

  // operand magnitudes and signs
  logic [MW-1:0] mag_a, mag_b;
  logic          neg_a, neg_b;
  assign neg_a = opa_q[XW-1];
  assign neg_b = opb_q[XW-1];
  assign mag_a = MW'(neg_a ? -opa_q : opa_q);
  assign mag_b = MW'(neg_b ? -opb_q : opb_q);

  // ops that write the register file at start
  logic signed [XW:0]   ea, eb;
  logic signed [XW-1:0] sres;
  logic                 single;
  assign ea = {opa_q[XW-1], opa_q};
  assign eb = {opb_q[XW-1], opb_q};
  assign single = uop.op inside {kpvf_pkg::OP_ADD, kpvf_pkg::OP_SUB, kpvf_pkg::OP_SADD,
                                 kpvf_pkg::OP_ZERO, kpvf_pkg::OP_ONE, kpvf_pkg::OP_LDA,
                                 kpvf_pkg::OP_LDZ};

  always_comb begin
    case (uop.op)
      kpvf_pkg::OP_ADD:  sres = sat_w(ea + eb);
      kpvf_pkg::OP_SUB:  sres = sat_w(ea - eb);
      kpvf_pkg::OP_SADD: sres = XW'(ea + eb);
      kpvf_pkg::OP_ONE:  sres = OneVal;
      kpvf_pkg::OP_LDA:  sres = sat_w({{(XW+1-IW){accel_q[IW-1]}}, accel_q});
      kpvf_pkg::OP_LDZ:  sres = sat_w({{(XW+1-IW){meas_q[IW-1]}}, meas_q});
      default:           sres = '0;
    endcase
  end

  // multiplier step and final rounding
  logic [PW-1:0]        acc_d, mrnd, mshr, mlim, msat;
  logic signed [XW-1:0] mres;
  int unsigned          sh;
  assign sh    = kpvf_pkg::FracP + int'(uop.shf);
  assign acc_d = (acc_q << 16) + (PW'(ua_q) * PW'(mb_q[16*NCH-1 -: 16]));
  assign mrnd  = acc_q + (PW'(1) << (sh - 1));
  assign mshr  = mrnd >> sh;
  assign mlim  = PW'(WMaxL) + PW'(mneg_q);
  assign msat  = (mshr > mlim) ? mlim : mshr;
  assign mres  = mneg_q ? -XW'(msat) : XW'(msat);

  // divider step and final rounding
  logic [XW+1:0]        dstep;
  logic                 dge;
  logic [XW:0]          rem_d;
  logic [NB:0]          qr, dlim, dsat;
  logic signed [XW-1:0] dres;
  assign dstep = {rem_q, dvd_q[NB-1]};
  assign dge   = dstep >= {2'b00, den_q};
  assign rem_d = dge ? (XW+1)'(dstep - {2'b00, den_q}) : (XW+1)'(dstep);
  assign qr    = ({1'b0, quo_q} + (NB+1)'(1)) >> 1;
  assign dlim  = (NB+1)'(WMaxL) + (NB+1)'(dneg_q);
  always_comb begin
    if ((quo_q >> (kpvf_pkg::FracP + 1)) > QIntMax) dsat = dlim;
    else if (qr > dlim) dsat = dlim;
    else dsat = qr;
  end
  assign dres = dneg_q ? -XW'(dsat) : XW'(dsat);

  // write port select
  always_comb begin
    wr_en   = 1'b0;
    wr_data = sres;
    if (mul_busy_q && (mcnt_q == '0)) begin
      wr_en   = 1'b1;
      wr_data = mres;
    end else if (div_busy_q && (dcnt_q == '0)) begin
      wr_en   = 1'b1;
      wr_data = dres;
    end else if (cmd_i.start && single) begin
      wr_en   = 1'b1;
    end
  end

  // register file write
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[uop.dst] <= wr_data;
    end
  end

  // registered operand reads, configuration sources muxed in
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      case (uop.a)
        kpvf_pkg::A_DT: opa_q <= XW'(time_step_i);
        kpvf_pkg::A_QN: opa_q <= XW'(q_scale_i);
        kpvf_pkg::A_RN: opa_q <= XW'(r_var_i);
        default:        opa_q <= mem_q[uop.a];
      endcase
      case (uop.b)
        kpvf_pkg::A_DT: opb_q <= XW'(time_step_i);
        kpvf_pkg::A_QN: opb_q <= XW'(q_scale_i);
        kpvf_pkg::A_RN: opb_q <= XW'(r_var_i);
        default:        opb_q <= mem_q[uop.b];
      endcase
    end
  end

  // unit sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q     <= 1'b0;
      nonpos_q   <= 1'b0;
      mul_busy_q <= 1'b0;
      div_busy_q <= 1'b0;
      mcnt_q     <= '0;
      dcnt_q     <= '0;
    end else begin
      done_q <= (cmd_i.start && !(uop.op inside {kpvf_pkg::OP_MUL, kpvf_pkg::OP_DIV})) ||
                (mul_busy_q && (mcnt_q == '0)) || (div_busy_q && (dcnt_q == '0));
      if (cmd_i.start) begin
        case (uop.op)
          kpvf_pkg::OP_MUL: begin
            mul_busy_q <= 1'b1;
            mcnt_q     <= MCW'(NCH);
          end
          kpvf_pkg::OP_DIV: begin
            div_busy_q <= 1'b1;
            dcnt_q     <= DCW'(NB);
          end
          kpvf_pkg::OP_CHK: begin
            nonpos_q <= (opa_q <= 0);
          end
          default: ;
        endcase
      end
      if (mul_busy_q) begin
        if (mcnt_q != '0) begin
          mcnt_q <= mcnt_q - MCW'(1);
        end else begin
          mul_busy_q <= 1'b0;
        end
      end
      if (div_busy_q) begin
        if (dcnt_q != '0) begin
          dcnt_q <= dcnt_q - DCW'(1);
        end else begin
          div_busy_q <= 1'b0;
        end
      end
    end
  end

  // unit payload, input capture and result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      accel_q <= accel_i;
      meas_q  <= meas_i;
    end
    if (cmd_i.start) begin
      acc_q  <= '0;
      ua_q   <= mag_a;
      mb_q   <= (16*NCH)'(mag_b);
      mneg_q <= neg_a ^ neg_b;
      rem_q  <= '0;
      quo_q  <= '0;
      dvd_q  <= {mag_a, {(kpvf_pkg::FracP + 1){1'b0}}};
      den_q  <= opb_q;
      dneg_q <= neg_a;
    end
    if (mul_busy_q && (mcnt_q != '0)) begin
      acc_q <= acc_d;
      mb_q  <= mb_q << 16;
    end
    if (div_busy_q && (dcnt_q != '0)) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[NB-2:0], dge};
      dvd_q <= dvd_q << 1;
    end
    if (cmd_i.out_load) begin
      position_o <= sat_out(opa_q);
      velocity_o <= sat_out(opb_q);
      fault_o    <= cmd_i.fault;
    end
  end

  assign stat_o.done   = done_q;
  assign stat_o.nonpos = nonpos_q;

endmodule

@@ rtl/kpvf_ctrl.sv @@
`timescale 1ns / 1ps
// kpvf_ctrl: micro-program sequencer and request handshake control.
// Depends on kpvf_pkg.
module kpvf_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic [1:0]      in_mode_i,
  output logic            in_ready_o,
  input  logic            out_ready_i,
  output logic            out_valid_o,
  input  kpvf_pkg::stat_t stat_i,
  output kpvf_pkg::cmd_t  cmd_o
);

  typedef enum logic [2:0] {ST_IDLE, ST_READ, ST_START, ST_WAIT, ST_OUT} state_e;

  state_e                      state_q;
  logic [kpvf_pkg::PcW-1:0]    pc_q, pc_start;
  logic                        init_q, fault_q, out_valid_q;
  kpvf_pkg::uop_t              uop;
  logic                        slot_free;

  assign uop       = kpvf_pkg::prog(pc_q);
  assign slot_free = !out_valid_q || out_ready_i;

  // entry point per mode
  always_comb begin
    case (in_mode_i)
      kpvf_pkg::ModePredict: pc_start = kpvf_pkg::PcPredict;
      kpvf_pkg::ModeUpdate:  pc_start = kpvf_pkg::PcUpdate;
      kpvf_pkg::ModeReset:   pc_start = kpvf_pkg::PcClear;
      default:               pc_start = kpvf_pkg::PcEnd;
    endcase
  end

  // command decode
  assign in_ready_o      = (state_q == ST_IDLE);
  assign out_valid_o     = out_valid_q;
  assign cmd_o.accept    = in_ready_o && in_valid_i;
  assign cmd_o.rd        = (state_q == ST_READ);
  assign cmd_o.start     = (state_q == ST_START);
  assign cmd_o.out_load  = (state_q == ST_OUT) && slot_free;
  assign cmd_o.fault     = fault_q;
  assign cmd_o.uop       = uop;

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_READ;
      pc_q        <= kpvf_pkg::PcClear;
      init_q      <= 1'b1;
      fault_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if ((state_q == ST_OUT) && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            pc_q    <= pc_start;
            fault_q <= 1'b0;
            state_q <= ST_READ;
          end
        end
        ST_READ: begin
          if (uop.op == kpvf_pkg::OP_END) begin
            if (init_q) begin
              init_q  <= 1'b0;
              state_q <= ST_IDLE;
            end else begin
              state_q <= ST_OUT;
            end
          end else begin
            state_q <= ST_START;
          end
        end
        ST_START: state_q <= ST_WAIT;
        ST_WAIT: begin
          if (stat_i.done) begin
            if ((uop.op == kpvf_pkg::OP_CHK) && stat_i.nonpos) begin
              fault_q <= 1'b1;
              pc_q    <= kpvf_pkg::PcEnd;
            end else begin
              pc_q <= pc_q + kpvf_pkg::PcW'(1);
            end
            state_q <= ST_READ;
          end
        end
        ST_OUT: begin
          if (slot_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // an accepted request always starts with an operand read
  a_accept_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |=> (state_q == ST_READ))
    else $error("accepted request did not start the program");

  // no unit completion while idle
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !stat_i.done)
    else $error("unit completion outside a program");

  // the program counter stays inside the program
  a_pc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (pc_q <= kpvf_pkg::PcEnd))
    else $error("program counter out of range");

  // a failed variance check marks the result as faulted
  a_fault_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_WAIT) && stat_i.done && stat_i.nonpos &&
     (uop.op == kpvf_pkg::OP_CHK)) |=> fault_q)
    else $error("variance fault not recorded");

endmodule

@@ tb/kpvf_checker.sv @@
`timescale 1ns / 1ps
// kpvf_checker: watches the request channels and the config port of the
// position/velocity filter, predicts every estimate and compares. Needs kpvf_pkg, kpvf_if.
module kpvf_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  kpvf_in_if          in_m,
  kpvf_out_if         out_m,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [kpvf_pkg::AddrWidth-1:0] paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          pending
);

  localparam longint WMax = (64'sd1 <<< 31) - 1;
  localparam longint WMin = -WMax - 1;

  typedef struct packed {
    logic signed [kpvf_pkg::IoWidth-1:0] pos;
    logic signed [kpvf_pkg::IoWidth-1:0] vel;
    logic                                fault;
  } estimate_t;

  estimate_t estimate_q[$];

  // filter copy
  logic [kpvf_pkg::TsWidth-1:0]    dt_cfg;
  logic [kpvf_pkg::NoiseWidth-1:0] qn_cfg;
  logic [kpvf_pkg::NoiseWidth-1:0] rn_cfg;
  longint pos_st, vel_st;
  longint cov[4];

  function automatic longint sat_word(longint v);
    if (v > WMax) return WMax;
    if (v < WMin) return WMin;
    return v;
  endfunction

  // exact product, rounded half away from zero, shifted by s, saturated
  function automatic longint mul_round(longint a, longint b, int s);
    logic [127:0] p;
    logic [63:0]  ua, ub, lim;
    bit neg;
    neg = (a < 0) != (b < 0);
    ua  = (a < 0) ? 64'(-a) : 64'(a);
    ub  = (b < 0) ? 64'(-b) : 64'(b);
    p   = {64'd0, ua} * {64'd0, ub};
    p   = (p + (128'd1 << (s - 1))) >> s;
    lim = neg ? 64'(WMax) + 64'd1 : 64'(WMax);
    if (p > {64'd0, lim}) p = {64'd0, lim};
    return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
  endfunction

  // num * 2^24 / den rounded half away from zero, saturated; den > 0
  function automatic longint gain_div(longint num, longint den);
    logic [127:0] q;
    logic [63:0]  un, lim;
    bit neg;
    neg = num < 0;
    un  = neg ? 64'(-num) : 64'(num);
    lim = neg ? 64'(WMax) + 64'd1 : 64'(WMax);
    q   = {64'd0, un} / {64'd0, 64'(den)};
    if (q > 128'(WMax >>> kpvf_pkg::FracP)) q = {64'd0, lim};
    else begin
      q = ((({64'd0, un} << (kpvf_pkg::FracP + 1)) / {64'd0, 64'(den)}) + 128'd1) >> 1;
      if (q > {64'd0, lim}) q = {64'd0, lim};
    end
    return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  task automatic clear_state();
    pos_st = 0;
    vel_st = 0;
    cov[0] = sat_word(64'sd1 <<< kpvf_pkg::FracP);
    cov[1] = 0;
    cov[2] = 0;
    cov[3] = sat_word(64'sd1 <<< kpvf_pkg::FracP);
  endtask

  task automatic predict_state(longint u);
    longint dt, q, d2, d3, d4, q00, q01, q11, n00, n01, n10, np, nv;
    dt  = longint'(dt_cfg);
    q   = longint'(qn_cfg);
    d2  = mul_round(dt, dt, 24);
    d3  = mul_round(d2, dt, 24);
    d4  = mul_round(d3, dt, 24);
    q00 = mul_round(q, d4, 26);
    q01 = mul_round(q, d3, 25);
    q11 = mul_round(q, d2, 24);
    n01 = sat_word(cov[1] + mul_round(dt, cov[3], 24));
    n10 = sat_word(cov[2] + mul_round(dt, cov[3], 24));
    n00 = sat_word(sat_word(cov[0] + mul_round(dt, cov[2], 24)) + mul_round(dt, n01, 24));
    np  = sat_word(sat_word(pos_st + mul_round(dt, vel_st, 24)) + mul_round(u, d2, 25));
    nv  = sat_word(vel_st + mul_round(dt, u, 24));
    cov[0] = sat_word(n00 + q00);
    cov[1] = sat_word(n01 + q01);
    cov[2] = sat_word(n10 + q01);
    cov[3] = sat_word(cov[3] + q11);
    pos_st = np;
    vel_st = nv;
  endtask

  // returns 1 when the innovation variance is not positive
  function automatic bit update_state(longint z);
    longint p00, p01, p10, p11, s, k0, k1, y;
    p00 = cov[0];
    p01 = cov[1];
    p10 = cov[2];
    p11 = cov[3];
    s   = p11 + longint'(rn_cfg);
    if (s <= 0) return 1'b1;
    k0 = gain_div(p01, s);
    k1 = gain_div(p11, s);
    y  = sat_word(z - vel_st);
    pos_st = sat_word(pos_st + mul_round(k0, y, 24));
    vel_st = sat_word(vel_st + mul_round(k1, y, 24));
    cov[0] = sat_word(p00 - mul_round(k0, p10, 24));
    cov[1] = sat_word(p01 - mul_round(k0, p11, 24));
    cov[2] = sat_word(p10 - mul_round(k1, p10, 24));
    cov[3] = sat_word(p11 - mul_round(k1, p11, 24));
    return 1'b0;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    estimate_t e, got;
    bit flt;
    if (!rst_ni) begin
      dt_cfg = kpvf_pkg::TsReset;
      qn_cfg = kpvf_pkg::PnReset;
      rn_cfg = kpvf_pkg::RnReset;
      clear_state();
      estimate_q.delete();
    end else begin
      // register writes
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          kpvf_pkg::RegTimeStep:     dt_cfg = pwdata[kpvf_pkg::TsWidth-1:0];
          kpvf_pkg::RegProcessNoise: qn_cfg = pwdata[kpvf_pkg::NoiseWidth-1:0];
          kpvf_pkg::RegMeasureNoise: rn_cfg = pwdata[kpvf_pkg::NoiseWidth-1:0];
          default: ;
        endcase
      end
      // accepted request: predict its estimate
      if (in_m.valid && in_m.ready) begin
        flt = 1'b0;
        case (in_m.mode)
          kpvf_pkg::ModePredict: predict_state(longint'(in_m.accel));
          kpvf_pkg::ModeUpdate:  flt = update_state(longint'(in_m.measured_velocity));
          kpvf_pkg::ModeReset:   clear_state();
          default: ;
        endcase
        e.pos   = pos_st[31:0];
        e.vel   = vel_st[31:0];
        e.fault = flt;
        estimate_q.push_back(e);
      end
      // accepted result: compare with the oldest estimate
      if (out_m.valid && out_m.ready) begin
        got.pos   = out_m.position_estimate;
        got.vel   = out_m.velocity_estimate;
        got.fault = out_m.divide_fault;
        if (estimate_q.size() == 0) begin
          report_mismatch("unexpected result", got.pos, 0);
        end else begin
          e = estimate_q.pop_front();
          if (got.pos !== e.pos) report_mismatch("position", got.pos, e.pos);
          if (got.vel !== e.vel) report_mismatch("velocity", got.vel, e.vel);
          if (got.fault !== e.fault) report_mismatch("divide_fault", got.fault, e.fault);
        end
      end
    end
    pending = estimate_q.size();
  end
endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// testbench: stimulus and verdict for kalman_position_velocity_filter_core.
// Needs kpvf_pkg, kpvf_if, the rtl, and kpvf_checker for prediction.
module testbench;

  localparam int IdleLimit = 20000;
  // mode value with no operation
  localparam logic [1:0] ModeSpare = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [kpvf_pkg::AddrWidth-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  int fail_count, pending;
  int idle_cycles = 0;

  kpvf_in_if  req_ch ();
  kpvf_out_if est_ch ();

  always #10 clk_i = ~clk_i;

  kalman_position_velocity_filter_core DUT (
    .clk_i, .rst_ni, .in_i(req_ch), .out_o(est_ch),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  kpvf_checker u_checker (
    .clk_i, .rst_ni, .in_m(req_ch), .out_m(est_ch),
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .fail_count, .pending
  );

  // gap lengths: mostly short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(0, 2);
    if (r < 95) return $urandom_range(3, 10);
    return $urandom_range(50, 300);
  endfunction

  // watchdog on accepted requests and results
  always @(posedge clk_i) begin
    if ((req_ch.valid && req_ch.ready) || (est_ch.valid && est_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result side: stalls of random length, with calm stretches
  initial begin
    int run, gap;
    est_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      est_ch.ready <= 1'b1;
      run = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400) : $urandom_range(1, 4);
      repeat (run) @(posedge clk_i);
      gap = pick_gap();
      if (gap > 0) begin
        est_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  end

  task automatic reg_write(logic [1:0] idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= kpvf_pkg::AddrWidth'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_filter(logic [31:0] dt, logic [31:0] qn, logic [31:0] rn);
    reg_write(kpvf_pkg::RegTimeStep, dt);
    reg_write(kpvf_pkg::RegProcessNoise, qn);
    reg_write(kpvf_pkg::RegMeasureNoise, rn);
  endtask

  // one request with a leading gap; valid stays high into the next request
  task automatic send_request(logic [1:0] mode, logic [31:0] acc, logic [31:0] mv, int gap);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_ch.valid             <= 1'b1;
    req_ch.mode              <= mode;
    req_ch.accel             <= acc;
    req_ch.measured_velocity <= mv;
    do @(posedge clk_i); while (!req_ch.ready);
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
    if (r < 8) return $urandom();
    if (r == 8) return 32'h7fff_ffff;
    return 32'h8000_0000;
  endfunction

  initial begin
    logic [1:0] mode;
    int r;
    req_ch.valid             <= 1'b0;
    req_ch.mode              <= kpvf_pkg::ModePredict;
    req_ch.accel             <= '0;
    req_ch.measured_velocity <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes of the fields at the reset settings
    send_request(kpvf_pkg::ModeReset, 32'h0, 32'h0, 0);
    send_request(kpvf_pkg::ModeUpdate, 32'h0, 32'h7fff_ffff, 0);
    send_request(kpvf_pkg::ModePredict, 32'h7fff_ffff, 32'h0, 1);
    send_request(kpvf_pkg::ModePredict, 32'h8000_0000, 32'hffff_ffff, 0);
    send_request(kpvf_pkg::ModeUpdate, 32'hffff_ffff, 32'h8000_0000, 2);
    send_request(ModeSpare, 32'hffff_ffff, 32'hffff_ffff, 0);
    send_request(kpvf_pkg::ModePredict, 32'h0001_0000, 32'h0, 0);
    send_request(kpvf_pkg::ModeUpdate, 32'h0, 32'h0002_0000, 0);
    send_request(kpvf_pkg::ModeReset, 32'hffff_ffff, 32'hffff_ffff, 0);
    wait_drained();

    // directed: zero noise drives the innovation variance to zero
    set_filter(32'd167772, 32'd0, 32'd0);
    send_request(kpvf_pkg::ModeReset, 32'h0, 32'h0, 0);
    send_request(kpvf_pkg::ModeUpdate, 32'h0, 32'h0001_0000, 0);
    send_request(kpvf_pkg::ModeUpdate, 32'h0, 32'h0003_0000, 0);
    send_request(kpvf_pkg::ModePredict, 32'h0, 32'h0, 0);
    send_request(kpvf_pkg::ModeUpdate, 32'h0, 32'h0, 0);
    wait_drained();

    // directed: largest settings
    set_filter(32'h00ff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_request(kpvf_pkg::ModePredict, 32'h7fff_ffff, 32'h0, 0);
    send_request(kpvf_pkg::ModePredict, 32'h7fff_ffff, 32'h0, 0);
    send_request(kpvf_pkg::ModeUpdate, 32'h0, 32'h8000_0000, 0);
    send_request(kpvf_pkg::ModePredict, 32'h8000_0000, 32'h0, 0);
    send_request(kpvf_pkg::ModeUpdate, 32'h0, 32'h7fff_ffff, 0);
    wait_drained();

    // random phases, each behind its own settings
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_filter(32'd167772, 32'd838861, 32'd16777);
        1: set_filter(32'd0, 32'd0, 32'd16777);
        2: set_filter(32'h00ff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        3: set_filter(32'd0, 32'h7fff_ffff, 32'd0);
        default: set_filter($urandom(), $urandom(), $urandom());
      endcase
      send_request(kpvf_pkg::ModeReset, 32'h0, 32'h0, pick_gap());
      repeat (120) begin
        r = $urandom_range(0, 99);
        if (r < 50) mode = kpvf_pkg::ModePredict;
        else if (r < 90) mode = kpvf_pkg::ModeUpdate;
        else if (r < 95) mode = kpvf_pkg::ModeReset;
        else mode = ModeSpare;
        send_request(mode, pick_value(), pick_value(), pick_gap());
      end
      wait_drained();
    end

    repeat (300) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

@@ files.f @@
rtl/kpvf_pkg.sv
rtl/kpvf_if.sv
rtl/kpvf_datapath.sv
rtl/kpvf_ctrl.sv
rtl/kalman_position_velocity_filter_core.sv
tb/kpvf_checker.sv
tb/testbench.sv
